// ===== src/dwl_pkg.sv =====
// shared types and constants for the dual white led fade mixer
// no dependencies; imported by dual_white_led_fade_mixer_top
package dwl_pkg;

  // input word: one command, shift start or refresh tick
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [30:0] duration_ms;
    logic [7:0]  start_amp;
    logic [7:0]  end_amp;
    logic [7:0]  start_temp;
    logic [7:0]  end_temp;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] warm_level;
    logic [7:0] cool_level;
    logic [7:0] amp_now;
    logic [7:0] temp_now;
    logic       fading;
    logic       drive_written;
  } out_word_t;

  // command codes
  localparam logic [1:0] MODE_SET     = 2'd0;
  localparam logic [1:0] MODE_SHIFT   = 2'd1;
  localparam logic [1:0] MODE_REFRESH = 2'd2;

  // arithmetic constants
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned QUOT_W     = 10;
  localparam int unsigned PROD_W     = LEN_W + QUOT_W;
  localparam int unsigned CNT_W      = 4;
  localparam logic [QUOT_W-1:0] PROG_SCALE = QUOT_W'(1000);
  localparam logic [7:0]        LEVEL_MAX  = 8'd255;

  // operations of the shared multiply and divide unit
  localparam logic [2:0] OP_PROG = 3'd0;
  localparam logic [2:0] OP_AMP  = 3'd1;
  localparam logic [2:0] OP_TEMP = 3'd2;
  localparam logic [2:0] OP_WARM = 3'd3;
  localparam logic [2:0] OP_COOL = 3'd4;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_NEXT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

endpackage

// ===== src/dual_white_led_fade_mixer_top.sv =====
// dual white led fade mixer: set points, linear shift and warm/cool levels
// one shared multiplier plus a 10-step restoring divider under a sequencer
// depends on dwl_pkg
//
// set, shift start, unused mode and non-interpolating refresh ticks run two divisions;
//   a refresh tick inside a running shift runs five divisions
// handshake: one word at a time; in_ready_o is low from accept until the
//   result is taken
// reset: asynchronous active low, clears all set points, shift state and control
module dual_white_led_fade_mixer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dwl_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dwl_pkg::out_word_t out_word_o
);
  import dwl_pkg::*;

  // sequencer and datapath registers
  logic [2:0]        state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [LEN_W-1:0]  div_q, div_d;
  logic [LEN_W-1:0]  elapsed_q, elapsed_d;
  logic [QUOT_W-1:0] progress_q, progress_d;
  logic [7:0]        lvl_a_q, lvl_a_d;
  logic [7:0]        lvl_t_q, lvl_t_d;
  logic [7:0]        warm_q, warm_d;
  logic [7:0]        cool_q, cool_d;
  logic              written_q, written_d;

  // shift state
  logic [TIME_W-1:0] begin_q, begin_d;
  logic [LEN_W-1:0]  length_q, length_d;
  logic [7:0]        org_amp_q, org_amp_d;
  logic [7:0]        tgt_amp_q, tgt_amp_d;
  logic [7:0]        org_temp_q, org_temp_d;
  logic [7:0]        tgt_temp_q, tgt_temp_d;
  logic [7:0]        amp_sp_q, amp_sp_d;
  logic [7:0]        temp_sp_q, temp_sp_d;
  logic              pending_q, pending_d;

  logic              in_fire;
  logic [TIME_W-1:0] elapsed;
  logic              in_motion;
  logic [LEN_W-1:0]  mul_a;
  logic [QUOT_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  div_sel;
  logic [LEN_W:0]    shifted;
  logic [LEN_W+1:0]  trial;
  logic              amp_neg, temp_neg;
  logic [7:0]        amp_mag, temp_mag;
  logic [7:0]        amp_new, temp_new;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_fire     = in_valid_i && in_ready_o;

  // wrapping elapsed time and shift window test
  assign elapsed   = in_word_i.now_ms - begin_q;
  assign in_motion = pending_q && (elapsed < {1'b0, length_q});

  // signed spans of the two set points
  assign amp_neg  = tgt_amp_q < org_amp_q;
  assign temp_neg = tgt_temp_q < org_temp_q;
  assign amp_mag  = amp_neg ? (org_amp_q - tgt_amp_q) : (tgt_amp_q - org_amp_q);
  assign temp_mag = temp_neg ? (org_temp_q - tgt_temp_q) : (tgt_temp_q - org_temp_q);

  // truncate toward zero: apply quotient magnitude with the span's sign
  assign amp_new  = amp_neg ? (org_amp_q - quot_q[7:0]) : (org_amp_q + quot_q[7:0]);
  assign temp_new = temp_neg ? (org_temp_q - quot_q[7:0]) : (org_temp_q + quot_q[7:0]);

  // shared multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_sel = LEN_W'(LEVEL_MAX);
    unique case (op_q)
      OP_PROG: begin
        mul_a   = elapsed_q;
        mul_b   = PROG_SCALE;
        div_sel = length_q;
      end
      OP_AMP: begin
        mul_a   = LEN_W'(amp_mag);
        mul_b   = progress_q;
        div_sel = LEN_W'(PROG_SCALE);
      end
      OP_TEMP: begin
        mul_a   = LEN_W'(temp_mag);
        mul_b   = progress_q;
        div_sel = LEN_W'(PROG_SCALE);
      end
      OP_WARM: begin
        mul_a   = LEN_W'(lvl_a_q);
        mul_b   = QUOT_W'(lvl_t_q);
      end
      OP_COOL: begin
        mul_a   = LEN_W'(lvl_a_q);
        mul_b   = QUOT_W'(LEVEL_MAX - lvl_t_q);
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // one restoring divide step
  assign shifted = {rem_q, quot_q[QUOT_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, div_q};

  // sequencer and next state
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quot_d     = quot_q;
    div_d      = div_q;
    elapsed_d  = elapsed_q;
    progress_d = progress_q;
    lvl_a_d    = lvl_a_q;
    lvl_t_d    = lvl_t_q;
    warm_d     = warm_q;
    cool_d     = cool_q;
    written_d  = written_q;
    begin_d    = begin_q;
    length_d   = length_q;
    org_amp_d  = org_amp_q;
    tgt_amp_d  = tgt_amp_q;
    org_temp_d = org_temp_q;
    tgt_temp_d = tgt_temp_q;
    amp_sp_d   = amp_sp_q;
    temp_sp_d  = temp_sp_q;
    pending_d  = pending_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MUL;
          op_d    = OP_WARM;
          lvl_a_d = amp_sp_q;
          lvl_t_d = temp_sp_q;
          unique case (in_word_i.mode)
            MODE_SET: begin
              amp_sp_d  = in_word_i.end_amp;
              temp_sp_d = in_word_i.end_temp;
              lvl_a_d   = in_word_i.end_amp;
              lvl_t_d   = in_word_i.end_temp;
              written_d = 1'b0;
            end
            MODE_SHIFT: begin
              begin_d    = in_word_i.now_ms;
              length_d   = in_word_i.duration_ms;
              org_amp_d  = in_word_i.start_amp;
              tgt_amp_d  = in_word_i.end_amp;
              org_temp_d = in_word_i.start_temp;
              tgt_temp_d = in_word_i.end_temp;
              pending_d  = 1'b1;
              lvl_a_d    = in_word_i.start_amp;
              lvl_t_d    = in_word_i.start_temp;
              written_d  = 1'b1;
            end
            MODE_REFRESH: begin
              written_d = 1'b1;
              if (in_motion) begin
                elapsed_d = elapsed[LEN_W-1:0];
                op_d      = OP_PROG;
              end else if (pending_q) begin
                // shift done: snap to targets
                amp_sp_d  = tgt_amp_q;
                temp_sp_d = tgt_temp_q;
                lvl_a_d   = tgt_amp_q;
                lvl_t_d   = tgt_temp_q;
                pending_d = 1'b0;
              end
            end
            default: begin
              written_d = 1'b0;
            end
          endcase
        end
      end
      ST_MUL: begin
        // load dividend high part as remainder, low part into quotient shifter
        rem_d   = prod[PROD_W-1:QUOT_W];
        quot_d  = prod[QUOT_W-1:0];
        div_d   = div_sel;
        cnt_d   = CNT_W'(QUOT_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (trial[LEN_W+1]) begin
          rem_d  = shifted[LEN_W-1:0];
          quot_d = {quot_q[QUOT_W-2:0], 1'b0};
        end else begin
          rem_d  = trial[LEN_W-1:0];
          quot_d = {quot_q[QUOT_W-2:0], 1'b1};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_d = ST_MUL;
        unique case (op_q)
          OP_PROG: begin
            progress_d = quot_q;
            op_d       = OP_AMP;
          end
          OP_AMP: begin
            amp_sp_d = amp_new;
            lvl_a_d  = amp_new;
            op_d     = OP_TEMP;
          end
          OP_TEMP: begin
            temp_sp_d = temp_new;
            lvl_t_d   = temp_new;
            op_d      = OP_WARM;
          end
          OP_WARM: begin
            warm_d = quot_q[7:0];
            op_d   = OP_COOL;
          end
          default: begin
            cool_d  = quot_q[7:0];
            state_d = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and set point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_WARM;
      cnt_q      <= '0;
      written_q  <= 1'b0;
      begin_q    <= '0;
      length_q   <= '0;
      org_amp_q  <= '0;
      tgt_amp_q  <= '0;
      org_temp_q <= '0;
      tgt_temp_q <= '0;
      amp_sp_q   <= '0;
      temp_sp_q  <= '0;
      pending_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      cnt_q      <= cnt_d;
      written_q  <= written_d;
      begin_q    <= begin_d;
      length_q   <= length_d;
      org_amp_q  <= org_amp_d;
      tgt_amp_q  <= tgt_amp_d;
      org_temp_q <= org_temp_d;
      tgt_temp_q <= tgt_temp_d;
      amp_sp_q   <= amp_sp_d;
      temp_sp_q  <= temp_sp_d;
      pending_q  <= pending_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quot_q     <= quot_d;
    div_q      <= div_d;
    elapsed_q  <= elapsed_d;
    progress_q <= progress_d;
    lvl_a_q    <= lvl_a_d;
    lvl_t_q    <= lvl_t_d;
    warm_q     <= warm_d;
    cool_q     <= cool_d;
  end

  // result word
  assign out_word_o.warm_level    = warm_q;
  assign out_word_o.cool_level    = cool_q;
  assign out_word_o.amp_now       = amp_sp_q;
  assign out_word_o.temp_now      = temp_sp_q;
  assign out_word_o.fading        = pending_q;
  assign out_word_o.drive_written = written_q;

  // checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is held");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MUL))
    else $error("accepted word did not start the unit");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && (cnt_q == '0)) |=> (state_q == ST_NEXT))
    else $error("divider did not finish after its last step");

  a_fade_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_NEXT) && (op_q == OP_PROG)) |-> (quot_q < PROG_SCALE))
    else $error("shift progress out of range");

endmodule

// ===== tb/tb_dual_white_led_fade_mixer_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for dual_white_led_fade_mixer_top: directed rows, then random
// shift sequences checked against a behavioral fade predictor; depends on dwl_pkg
module tb_dual_white_led_fade_mixer_top;
  import dwl_pkg::*;

  // unused command code, the block leaves set points and shift state unchanged for it
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_WORDS = 384;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t e;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  stim_row_t stim_q[$];
  stim_row_t dir_rows[$];
  stim_row_t cur_row;
  out_word_t level_q[$];
  int        err_cnt = 0;
  int        stall_cnt = 0;
  int        snd_idle = 0;
  int        rcv_idle = 0;

  // predictor state
  logic [31:0] fd_begin;
  logic [30:0] fd_len;
  logic [7:0]  fd_org_amp, fd_tgt_amp, fd_org_temp, fd_tgt_temp;
  logic [7:0]  fd_amp, fd_temp;
  logic        fd_active;

  dual_white_led_fade_mixer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // linear step between two set points, progress in thousandths, truncated toward zero
  function automatic logic [7:0] lerp_point(logic [7:0] from, logic [7:0] to,
                                            int unsigned prog);
    int diff;
    int delta;
    diff  = int'(to) - int'(from);
    delta = (int'(prog) * diff) / 1000;
    return 8'(int'(from) + delta);
  endfunction

  // warm and cool duty from brightness and temperature
  function automatic logic [15:0] mix_levels(logic [7:0] a, logic [7:0] t);
    int unsigned warm;
    int unsigned cool;
    warm = (int'(a) * int'(t)) / 255;
    cool = (int'(a) * (255 - int'(t))) / 255;
    return {8'(warm), 8'(cool)};
  endfunction

  // advance the predictor by one word and return the expected result
  function automatic out_word_t fade_predict(in_word_t w);
    out_word_t   r;
    logic [31:0] elapsed;
    longint unsigned prog;
    r = '0;
    case (w.mode)
      MODE_SET: begin
        fd_amp  = w.end_amp;
        fd_temp = w.end_temp;
        {r.warm_level, r.cool_level} = mix_levels(fd_amp, fd_temp);
      end
      MODE_SHIFT: begin
        fd_begin    = w.now_ms;
        fd_len      = w.duration_ms;
        fd_org_amp  = w.start_amp;
        fd_tgt_amp  = w.end_amp;
        fd_org_temp = w.start_temp;
        fd_tgt_temp = w.end_temp;
        fd_active   = 1'b1;
        {r.warm_level, r.cool_level} = mix_levels(w.start_amp, w.start_temp);
        r.drive_written = 1'b1;
      end
      MODE_REFRESH: begin
        if (fd_active) begin
          elapsed = w.now_ms - fd_begin;
          if (elapsed < {1'b0, fd_len}) begin
            prog    = (longint'(elapsed) * 1000) / longint'(fd_len);
            fd_amp  = lerp_point(fd_org_amp, fd_tgt_amp, int'(prog));
            fd_temp = lerp_point(fd_org_temp, fd_tgt_temp, int'(prog));
          end else begin
            fd_amp    = fd_tgt_amp;
            fd_temp   = fd_tgt_temp;
            fd_active = 1'b0;
          end
        end
        {r.warm_level, r.cool_level} = mix_levels(fd_amp, fd_temp);
        r.drive_written = 1'b1;
      end
      default: begin
        {r.warm_level, r.cool_level} = mix_levels(fd_amp, fd_temp);
      end
    endcase
    r.amp_now  = fd_amp;
    r.temp_now = fd_temp;
    r.fading   = fd_active;
    return r;
  endfunction

  function automatic in_word_t mk_word(logic [1:0] mode, logic [31:0] now,
                                       logic [30:0] dur, logic [7:0] sa, logic [7:0] ea,
                                       logic [7:0] st, logic [7:0] et);
    in_word_t w;
    w.mode        = mode;
    w.now_ms      = now;
    w.duration_ms = dur;
    w.start_amp   = sa;
    w.end_amp     = ea;
    w.start_temp  = st;
    w.end_temp    = et;
    return w;
  endfunction

  function automatic out_word_t mk_result(logic [7:0] warm, logic [7:0] cool,
                                          logic [7:0] amp, logic [7:0] temp,
                                          logic fading, logic written);
    out_word_t r;
    r.warm_level    = warm;
    r.cool_level    = cool;
    r.amp_now       = amp;
    r.temp_now      = temp;
    r.fading        = fading;
    r.drive_written = written;
    return r;
  endfunction

  function automatic in_word_t rand_word(logic [1:0] mode);
    return mk_word(mode, $urandom, 31'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
  endfunction

  task automatic add_row(ref stim_row_t q[$], input in_word_t w, input bit typed,
                         input out_word_t e);
    stim_row_t r;
    r.w     = w;
    r.typed = typed;
    r.e     = e;
    q.push_back(r);
  endtask

  // random part: mostly shift starts followed by refresh ticks inside or past the shift
  task automatic add_random(int unsigned n);
    in_word_t    w;
    int unsigned k;
    int unsigned kind;
    int unsigned span;
    logic [31:0] t0;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        w = rand_word(MODE_SHIFT);
        case ($urandom_range(0, 9))
          0, 1:    w.duration_ms = 31'($urandom_range(0, 3));
          2, 3:    w.duration_ms = 31'($urandom);
          4:       w.duration_ms = '1;
          default: w.duration_ms = 31'($urandom_range(1, 5000));
        endcase
        t0   = w.now_ms;
        span = int'(w.duration_ms) + int'(w.duration_ms) / 4 + 1;
        add_row(stim_q, w, 1'b0, '0);
        k++;
        repeat ($urandom_range(1, 8)) begin
          w = rand_word(MODE_REFRESH);
          if ($urandom_range(0, 9) == 0) begin
            w.mode = $urandom_range(0, 1) ? MODE_SET : MODE_UNUSED;
          end else if ($urandom_range(0, 9) != 0) begin
            w.now_ms = t0 + 32'($urandom_range(0, span));
          end
          add_row(stim_q, w, 1'b0, '0);
          k++;
        end
      end else if (kind < 85) begin
        add_row(stim_q, rand_word(MODE_SET), 1'b0, '0);
        k++;
      end else if (kind < 95) begin
        add_row(stim_q, rand_word(MODE_REFRESH), 1'b0, '0);
        k++;
      end else begin
        add_row(stim_q, rand_word(MODE_UNUSED), 1'b0, '0);
        k++;
      end
    end
  endtask

  // hold off until every queued word is taken and every result has come back
  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid_i || level_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      err_cnt++;
    end
  endtask

  // word source: predicts at acceptance, keeps valid high across back-to-back words
  always @(posedge clk_i) begin : feed
    logic      taken;
    out_word_t p;
    taken = in_valid_i && in_ready_o;
    if (taken) begin
      p = fade_predict(cur_row.w);
      if (cur_row.typed) begin
        p = cur_row.e;
      end
      level_q.push_back(p);
    end
    if (!in_valid_i || taken) begin
      if (stim_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
        cur_row = stim_q.pop_front();
        in_word_i  <= cur_row.w;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink and checker with random backpressure
  always @(posedge clk_i) begin : drain
    out_word_t e;
    if (out_valid_o && out_ready_i) begin
      if (level_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $time, out_word_o);
        err_cnt++;
      end else begin
        e = level_q.pop_front();
        check_field("warm_level", e.warm_level, out_word_o.warm_level);
        check_field("cool_level", e.cool_level, out_word_o.cool_level);
        check_field("amp_now", e.amp_now, out_word_o.amp_now);
        check_field("temp_now", e.temp_now, out_word_o.temp_now);
        check_field("fading", e.fading, out_word_o.fading);
        check_field("drive_written", e.drive_written, out_word_o.drive_written);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cnt >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : run
    int snd_pct[3];
    int rcv_pct[3];
    snd_pct = '{26, 76, 0};
    rcv_pct = '{76, 26, 0};
    fd_begin    = '0;
    fd_len      = '0;
    fd_org_amp  = '0;
    fd_tgt_amp  = '0;
    fd_org_temp = '0;
    fd_tgt_temp = '0;
    fd_amp      = '0;
    fd_temp     = '0;
    fd_active   = 1'b0;
    snd_idle    = snd_pct[0];
    rcv_idle    = rcv_pct[0];

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: reset state, level extremes, shift progress, wrap and snap cases
    add_row(dir_rows, mk_word(MODE_UNUSED, '1, '1, '1, '1, '1, '1), 1'b1,
            mk_result(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'h1234, '0, '0, '0, '0, '0), 1'b1,
            mk_result(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
    add_row(dir_rows, mk_word(MODE_SET, '0, '0, '0, 8'd255, '0, 8'd255), 1'b1,
            mk_result(8'd255, 8'd0, 8'd255, 8'd255, 1'b0, 1'b0));
    add_row(dir_rows, mk_word(MODE_SET, '0, '0, '0, 8'd255, '0, 8'd0), 1'b1,
            mk_result(8'd0, 8'd255, 8'd255, 8'd0, 1'b0, 1'b0));
    add_row(dir_rows, mk_word(MODE_SET, '0, '0, '0, 8'd0, '0, 8'd255), 1'b1,
            mk_result(8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0));
    add_row(dir_rows, mk_word(MODE_SET, '0, '0, '0, 8'd255, '0, 8'd128), 1'b0, '0);
    // plain shift: halfway, just before end, at end, then idle refresh
    add_row(dir_rows, mk_word(MODE_SHIFT, 32'd1000, 31'd1000, 8'd0, 8'd255, 8'd255, 8'd0),
            1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'd1500, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'd1999, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'd2000, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'd2500, '0, '0, '0, '0, '0), 1'b0, '0);
    // zero-length shift stays pending until the next refresh snaps it
    add_row(dir_rows, mk_word(MODE_SHIFT, 32'd5, 31'd0, 8'd255, 8'd0, 8'd0, 8'd255),
            1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'd5, '0, '0, '0, '0, '0), 1'b1,
            mk_result(8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1));
    // shift across the time counter wrap, then a tick from before the start
    add_row(dir_rows, mk_word(MODE_SHIFT, 32'hFFFF_FF00, 31'd512, 8'd10, 8'd200, 8'd200,
            8'd10), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'h0000_0080, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'hFFFF_FE00, '0, '0, '0, '0, '0), 1'b0, '0);
    // longest shift, set and unused words do not cancel it
    add_row(dir_rows, mk_word(MODE_SHIFT, 32'd0, '1, 8'd0, 8'd255, 8'd0, 8'd255), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'h7FFF_FFFE, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_SET, '0, '0, '0, 8'd7, '0, 8'd9), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_UNUSED, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'hFFFF_FFFF, '0, '0, '0, '0, '0), 1'b0, '0);
    // all-ones shift start, then a tick one ms later
    add_row(dir_rows, mk_word(MODE_SHIFT, '1, '1, '1, '1, '1, '1), 1'b0, '0);
    add_row(dir_rows, mk_word(MODE_REFRESH, 32'd0, '0, '0, '0, '0, '0), 1'b0, '0);

    foreach (dir_rows[i]) begin
      stim_q.push_back(dir_rows[i]);
    end
    // sender holds off until the directed results are all back
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = snd_pct[ph];
      rcv_idle = rcv_pct[ph];
      add_random(PHASE_WORDS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && level_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
